FILE: hdl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// Lagged Fibonacci generator package
// Widths, codes and the control bundle shared by the ring cells and the top.
// ----------------------------------------------------------------------------
package lfr_pkg;

   localparam int DATA_W        = 32;
   localparam int SLOT_W        = 6;
   localparam int MODE_W        = 2;
   localparam int REQ_TDATA_W   = 40;
   localparam int LONG_LAG_DEF  = 55;
   localparam int SHORT_LAG_DEF = 24;

   localparam logic [MODE_W-1:0] MODE_ADD32 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD16 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CARRY = 2'd2;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_GEN  = 1'b1;

   // Per-cycle command seen by every ring cell.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

FILE: hdl/lfr_cell.sv
// ----------------------------------------------------------------------------
// Ring cell
// One word of the generator ring; takes its neighbor's word on a shift and
// the request word when a load addresses this cell.
// ----------------------------------------------------------------------------
module lfr_cell #(
   parameter int INDEX = 0,
   parameter int PTR_W = 6
) (
   input  logic                        clock,
   input  lfr_pkg::cell_ctrl_type      ctrl,
   input  logic [PTR_W-1:0]            load_index,
   input  logic [lfr_pkg::DATA_W-1:0]  load_word,
   input  logic [lfr_pkg::DATA_W-1:0]  neighbor_word,
   output logic [lfr_pkg::DATA_W-1:0]  word
);
   import lfr_pkg::*;

   logic [DATA_W-1:0] word_ff;
   logic [DATA_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctrl.load && (load_index == PTR_W'(INDEX))) begin
         word_in = load_word;
      end else if (ctrl.shift) begin
         word_in = neighbor_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

FILE: hdl/lfr_out_buf.sv
// ----------------------------------------------------------------------------
// Output buffer
// Output register plus one skid entry, so a stall on the result side does not
// hold up the request side until the skid entry is full.
// ----------------------------------------------------------------------------
module lfr_out_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [lfr_pkg::DATA_W-1:0]  push_data,
   output logic                        full,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [lfr_pkg::DATA_W-1:0]  rsp_tdata
);
   import lfr_pkg::*;

   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [DATA_W-1:0] skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full       = skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: hdl/lagged_fibonacci_rng.sv
// ----------------------------------------------------------------------------
// Lagged Fibonacci random number generator
// Additive generator over a ring of LONG_LAG words held in a row of cells.
// ----------------------------------------------------------------------------
// Requests arrive on req_*: tuser selects a load (0) or a generate (1). A load
// stores one ring word and restarts the sequence; it returns nothing. A
// generate returns one value on rsp_*: the sum is formed in the accepting cycle
// and lands in the output register, or in the skid entry if rsp_* stalls.
// Generates are accepted every cycle unless the ring turns back or the buffer
// is full. The ring rotates by one cell on each generate, so the two operands
// always sit in cell 0 and cell LONG_LAG - SHORT_LAG.
// After a burst of loads the ring must be turned back to its home position
// before the next generate: req_tready stays low while it turns, one cell step
// per cycle, until the cell holding word zero is back in cell 0.
// The user must write the mode register on csr_* only while the block is idle;
// the block itself does not enforce this. Reset clears the mode, the pointers
// and the carry; ring contents are not cleared and must be loaded completely
// before generating. A stalled result side is absorbed by a two-entry output buffer; after that req_tready drops.
// ----------------------------------------------------------------------------
module lagged_fibonacci_rng #(
   parameter int LONG_LAG  = lfr_pkg::LONG_LAG_DEF,
   parameter int SHORT_LAG = lfr_pkg::SHORT_LAG_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lfr_pkg::REQ_TDATA_W-1:0]  req_tdata,  // slot[5:0], load_value[37:6]
   input  logic [0:0]                       req_tuser,  // action[0]
   // Result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lfr_pkg::DATA_W-1:0]       rsp_tdata,  // random_value[31:0]
   // Mode register
   input  logic                             csr_wr_en,
   input  logic [lfr_pkg::MODE_W-1:0]       csr_wr_data
);
   import lfr_pkg::*;

   localparam int PTR_W    = $clog2(LONG_LAG);
   localparam int CMP_W    = ((PTR_W > SLOT_W) ? PTR_W : SLOT_W) + 1;
   localparam int LAG_CELL = (LONG_LAG - SHORT_LAG) % LONG_LAG;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [PTR_W-1:0]  base_ff, base_in;
   logic              restart_ff, restart_in;
   logic              carry_ff, carry_in;

   logic [SLOT_W-1:0] req_slot;
   logic [DATA_W-1:0] req_load_value;
   logic              accept, gen, load, rotate, buf_full;

   logic [CMP_W-1:0]  slot_ext, base_ext, diff_ext;
   logic              slot_ok;
   logic [PTR_W-1:0]  load_index;
   cell_ctrl_type     ctrl;

   logic [DATA_W-1:0] ring_word [LONG_LAG];
   logic [DATA_W-1:0] feed_word;
   logic [DATA_W-1:0] op_a, op_b, sum, delta, result;
   logic              carry_next;

   assign req_slot       = req_tdata[SLOT_W-1:0];
   assign req_load_value = req_tdata[SLOT_W +: DATA_W];

   // After a load the logical write position is zero, so the ring is turned
   // until the cell holding word zero is back in cell 0.
   assign rotate     = restart_ff && (base_ff != '0);
   assign req_tready = !rotate && !buf_full;
   assign accept     = req_tvalid && req_tready;
   assign gen        = accept && (req_tuser[0] == ACTION_GEN);
   assign load       = accept && (req_tuser[0] == ACTION_LOAD);

   // Map the ring slot onto the cell that currently holds it.
   assign slot_ext = CMP_W'(req_slot);
   assign base_ext = CMP_W'(base_ff);
   assign slot_ok  = slot_ext < CMP_W'(LONG_LAG);
   always_comb begin
      if (slot_ext >= base_ext) begin
         diff_ext = slot_ext - base_ext;
      end else begin
         diff_ext = slot_ext + CMP_W'(LONG_LAG) - base_ext;
      end
   end
   assign load_index = diff_ext[PTR_W-1:0];

   assign ctrl.shift = gen || rotate;
   assign ctrl.load  = load && slot_ok;

   assign op_a = ring_word[0];
   assign op_b = ring_word[LAG_CELL];

   always_comb begin
      carry_next = carry_ff;
      if (mode_ff == MODE_CARRY) begin
         sum        = op_a + op_b + DATA_W'(carry_ff);
         delta      = sum - op_a;
         carry_next = delta[DATA_W-1] || ((sum == op_a) && (op_b != '0));
      end else begin
         sum   = op_a + op_b;
         delta = '0;
      end
      if (mode_ff == MODE_ADD16) begin
         result = sum >> (DATA_W / 2);
      end else begin
         result = sum;
      end
   end

   assign feed_word = rotate ? ring_word[0] : sum;

   for (genvar k = 0; k < LONG_LAG; k++) begin : g_ring
      logic [DATA_W-1:0] neighbor;
      if (k == LONG_LAG - 1) begin : g_tail
         assign neighbor = feed_word;
      end else begin : g_body
         assign neighbor = ring_word[k+1];
      end
      lfr_cell #(
         .INDEX (k),
         .PTR_W (PTR_W)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .load_index    (load_index),
         .load_word     (req_load_value),
         .neighbor_word (neighbor),
         .word          (ring_word[k])
      );
   end

   always_comb begin
      mode_in    = mode_ff;
      base_in    = base_ff;
      restart_in = restart_ff;
      carry_in   = carry_ff;
      if (csr_wr_en) begin
         mode_in = csr_wr_data;
      end
      if (gen || rotate) begin
         base_in = (base_ff == PTR_W'(LONG_LAG - 1)) ? '0 : base_ff + 1'b1;
      end
      if (load) begin
         restart_in = 1'b1;
         carry_in   = 1'b0;
      end else if (gen) begin
         restart_in = 1'b0;
         carry_in   = carry_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_ADD32;
         base_ff    <= '0;
         restart_ff <= 1'b0;
         carry_ff   <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         base_ff    <= base_in;
         restart_ff <= restart_in;
         carry_ff   <= carry_in;
      end
   end

   lfr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (gen),
      .push_data  (result),
      .full       (buf_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
